// ===== hw/rtl/jss_pkg.sv =====
// Shared constants for the Jacobi stencil sweep block.
package jss_pkg;

   // Width and reset value of the grid size register.
   localparam int GRID_SIZE_WIDTH = 12;
   localparam logic [GRID_SIZE_WIDTH-1:0] GRID_SIZE_RESET = 12'd2048;

   // Smallest grid that still has an interior point.
   localparam int MIN_GRID = 3;

   // Result queue depth; an item in the final row pushes two entries.
   localparam int RSP_DEPTH = 4;
   localparam int RSP_PTR_WIDTH = 2;
   localparam int RSP_CNT_WIDTH = 3;

endpackage

// ===== hw/rtl/jss_ram.sv =====
// Generic simple dual-port RAM with one write port and one registered read port.
module jss_ram #(
   parameter int WIDTH = 50,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/jacobi_stencil_sweep.sv =====
// Top level of the streaming Jacobi five-point stencil sweep.
//
//   channel   direction  signals                                   handshake
//   req       in         req_cell_value                            req_valid / req_ready
//   rsp       out        rsp_new_value, rsp_last_of_run,           rsp_valid / rsp_ready
//                        rsp_frame_done
//   csr       in         csr_write_data                            csr_write_enable
//
// One grid value is taken per cycle while req_ready is high; each transaction reads
// one line-buffer word and writes one back, so the single-port-pair RAM sets the rate.
// In the final row every transaction yields two results, so there the result port
// limits the rate. Each result is written to the result queue before it is offered.
// The line buffer needs no clearing pass.
// A stalled result port backs up a four-entry result queue before req_ready drops.
module jacobi_stencil_sweep #(
   parameter int MAX_COLUMNS   = 2048,
   parameter int FRACTION_BITS = 24
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [FRACTION_BITS:0]                req_cell_value,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [FRACTION_BITS:0]                rsp_new_value,
   output logic                                  rsp_last_of_run,
   output logic                                  rsp_frame_done,
   input  logic                                  csr_write_enable,
   input  logic [jss_pkg::GRID_SIZE_WIDTH-1:0]   csr_write_data
);

   localparam int VW = FRACTION_BITS + 1;
   localparam int AW = $clog2(MAX_COLUMNS);
   localparam int SW = $clog2(MAX_COLUMNS + 1);
   localparam int CW = (SW > jss_pkg::GRID_SIZE_WIDTH) ? SW : jss_pkg::GRID_SIZE_WIDTH;
   localparam int PW = SW + 1;

   // Result queue entry.
   typedef struct packed {
      logic [VW-1:0] value;
      logic          last;
      logic          done;
   } rsp_entry_type;

   // Line buffer word: previous row in the upper half, older row in the lower.
   typedef struct packed {
      logic [VW-1:0] prev;
      logic [VW-1:0] older;
   } line_word_type;

   logic [jss_pkg::GRID_SIZE_WIDTH-1:0] grid_ff, grid_in;
   logic [AW-1:0] col_ff, col_in;
   logic [AW-1:0] row_ff, row_in;
   logic [VW-1:0] left_ff, left_in;
   line_word_type cur_ff, cur_in;
   line_word_type rd_word;
   line_word_type wr_word;

   rsp_entry_type rsp_q_ff [jss_pkg::RSP_DEPTH];
   logic [jss_pkg::RSP_PTR_WIDTH-1:0] head_ff, head_in;
   logic [jss_pkg::RSP_PTR_WIDTH-1:0] tail_ff, tail_in;
   logic [jss_pkg::RSP_CNT_WIDTH-1:0] cnt_ff, cnt_in;

   logic [CW-1:0] size_wide;
   logic [SW-1:0] n_eff;
   logic [SW-1:0] n_last;
   logic [PW-1:0] col_next;
   logic [PW-1:0] col_ahead;
   logic [AW-1:0] rd_addr;
   logic          first_row;
   logic          final_row;
   logic          edge_col;
   logic          pass_through;
   logic          row_end;
   logic [1:0]    need;
   logic          accept;
   logic          pop;
   logic [VW+1:0] sum;
   logic [VW-1:0] stencil;
   rsp_entry_type ent0;
   rsp_entry_type ent1;
   rsp_entry_type head_ent;

   // Effective grid size: register value clamped to the supported range.
   always_comb begin
      size_wide = CW'(grid_ff);
      if (size_wide < CW'(jss_pkg::MIN_GRID)) begin
         n_eff = SW'(jss_pkg::MIN_GRID);
      end else if (size_wide > CW'(MAX_COLUMNS)) begin
         n_eff = SW'(MAX_COLUMNS);
      end else begin
         n_eff = size_wide[SW-1:0];
      end
      n_last = n_eff - SW'(1);
   end

   assign first_row    = (row_ff == '0);
   assign final_row    = (SW'(row_ff) == n_last);
   assign edge_col     = (col_ff == '0) || (SW'(col_ff) == n_last);
   assign pass_through = (row_ff == AW'(1)) || edge_col;

   always_comb begin
      if (first_row) begin
         need = 2'd0;
      end else if (final_row) begin
         need = 2'd2;
      end else begin
         need = 2'd1;
      end
   end

   assign req_ready = ({1'b0, cnt_ff} + {{(jss_pkg::RSP_CNT_WIDTH - 1){1'b0}}, need})
                      <= (jss_pkg::RSP_CNT_WIDTH + 1)'(jss_pkg::RSP_DEPTH);
   assign accept    = req_valid && req_ready;

   // The RAM output always holds the word of the column to the right of the current one.
   assign sum = {2'b00, cur_ff.older} + {2'b00, req_cell_value} + {2'b00, left_ff}
                + {2'b00, rd_word.prev};
   assign stencil = pass_through ? cur_ff.prev : sum[VW+1:2];

   always_comb begin
      ent0.value = stencil;
      ent0.last  = !final_row;
      ent0.done  = 1'b0;
      ent1.value = req_cell_value;
      ent1.last  = 1'b1;
      ent1.done  = (SW'(col_ff) == n_last);
   end

   // Column and look-ahead read address, both wrapping at the row length.
   always_comb begin
      col_next  = PW'(col_ff) + PW'(1);
      col_ahead = PW'(col_ff) + PW'(2);
      if (col_ahead >= PW'(n_eff)) begin
         col_ahead = col_ahead - PW'(n_eff);
      end
      row_end = (col_next >= PW'(n_eff));
      rd_addr = col_ahead[AW-1:0];
   end

   assign wr_word.prev  = req_cell_value;
   assign wr_word.older = cur_ff.prev;

   jss_ram #(
      .WIDTH (2 * VW),
      .DEPTH (MAX_COLUMNS)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (col_ff),
      .wr_data (wr_word),
      .rd_en   (accept),
      .rd_addr (rd_addr),
      .rd_data (rd_word)
   );

   assign pop       = rsp_valid && rsp_ready;
   assign head_ent  = rsp_q_ff[head_ff];
   assign rsp_valid = (cnt_ff != '0);
   assign rsp_new_value   = head_ent.value;
   assign rsp_last_of_run = head_ent.last;
   assign rsp_frame_done  = head_ent.done;

   always_comb begin
      grid_in = grid_ff;
      col_in  = col_ff;
      row_in  = row_ff;
      left_in = left_ff;
      cur_in  = cur_ff;
      if (csr_write_enable) begin
         grid_in = csr_write_data;
         col_in  = '0;
         row_in  = '0;
         left_in = '0;
      end else if (accept) begin
         cur_in  = rd_word;
         left_in = cur_ff.prev;
         col_in  = col_next[AW-1:0];
         if (row_end) begin
            col_in  = '0;
            left_in = '0;
            if (final_row) begin
               row_in = '0;
            end else begin
               row_in = row_ff + AW'(1);
            end
         end
      end
   end

   always_comb begin
      head_in = head_ff;
      tail_in = tail_ff;
      cnt_in  = cnt_ff;
      if (pop) begin
         head_in = head_ff + jss_pkg::RSP_PTR_WIDTH'(1);
      end
      if (accept) begin
         tail_in = tail_ff + jss_pkg::RSP_PTR_WIDTH'(need);
      end
      cnt_in = cnt_ff + (accept ? jss_pkg::RSP_CNT_WIDTH'(need) : '0)
               - jss_pkg::RSP_CNT_WIDTH'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_ff <= jss_pkg::GRID_SIZE_RESET;
         col_ff  <= '0;
         row_ff  <= '0;
         left_ff <= '0;
         head_ff <= '0;
         tail_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         grid_ff <= grid_in;
         col_ff  <= col_in;
         row_ff  <= row_in;
         left_ff <= left_in;
         head_ff <= head_in;
         tail_ff <= tail_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      if (accept && (need != 2'd0)) begin
         rsp_q_ff[tail_ff] <= ent0;
      end
      if (accept && (need == 2'd2)) begin
         rsp_q_ff[tail_ff + jss_pkg::RSP_PTR_WIDTH'(1)] <= ent1;
      end
   end

endmodule

// ===== hw/rtl/jss_checker.sv =====
// Port-level assertions for the Jacobi stencil sweep, bound to the top level.
module jss_checker #(
   parameter int VALUE_WIDTH = 25
) (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic [VALUE_WIDTH-1:0] rsp_new_value,
   input logic                   rsp_last_of_run,
   input logic                   rsp_frame_done
);

   // The result queue is empty after reset.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // An empty queue always has room for any transaction.
   a_reset_ready: assert property (@(posedge clock) reset |=> req_ready)
      else $error("request not ready right after reset");

   // The end of the grid is always the end of its transaction's results.
   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_frame_done) |-> rsp_last_of_run)
      else $error("frame_done without last_of_run");

   // A stalled result keeps its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_new_value)
                                     && $stable(rsp_last_of_run)
                                     && $stable(rsp_frame_done)))
      else $error("stalled result changed");

endmodule

bind jacobi_stencil_sweep jss_checker #(
   .VALUE_WIDTH (FRACTION_BITS + 1)
) u_jss_checker (
   .clock           (clock),
   .reset           (reset),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_new_value   (rsp_new_value),
   .rsp_last_of_run (rsp_last_of_run),
   .rsp_frame_done  (rsp_frame_done)
);

// ===== sim/jacobi_stencil_sweep_tb.sv =====
// Self-checking testbench for the streaming Jacobi five-point stencil sweep.
`timescale 1ns / 1ps

module jacobi_stencil_sweep_tb;

   localparam int MAX_COLS     = 2048;
   localparam int FRAC_BITS    = 24;
   localparam int CELL_W       = FRAC_BITS + 1;
   localparam logic [CELL_W-1:0] ONE_VAL = 25'h100_0000;
   localparam logic [CELL_W-1:0] MAX_VAL = 25'h1FF_FFFF;
   localparam int RANDOM_CELLS = 1450;
   localparam int WIDE_CELLS   = 40;
   localparam int SETTLE_CYCLES = 8;
   localparam int TAIL_CYCLES  = 20;
   localparam int QUIET_OPS    = 300;
   localparam int LONG_HOLD    = 300;
   localparam int CYCLE_LIMIT  = 1_000_000;

   typedef enum logic [1:0] {OP_CELL, OP_GRID, OP_DRAIN} op_kind_type;

   typedef struct {
      op_kind_type       kind;
      logic [CELL_W-1:0] value;
   } sweep_op_type;

   typedef struct packed {
      logic [CELL_W-1:0] new_value;
      logic              last_of_run;
      logic              frame_done;
   } sweep_out_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [CELL_W-1:0] req_cell_value = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [CELL_W-1:0] rsp_new_value;
   logic rsp_last_of_run;
   logic rsp_frame_done;
   logic csr_write_enable = 1'b0;
   logic [jss_pkg::GRID_SIZE_WIDTH-1:0] csr_write_data = '0;

   jacobi_stencil_sweep #(
      .MAX_COLUMNS   (MAX_COLS),
      .FRACTION_BITS (FRAC_BITS)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_cell_value   (req_cell_value),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_new_value    (rsp_new_value),
      .rsp_last_of_run  (rsp_last_of_run),
      .rsp_frame_done   (rsp_frame_done),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Stencil predictor state.
   logic [jss_pkg::GRID_SIZE_WIDTH-1:0] grid_reg = jss_pkg::GRID_SIZE_RESET;
   logic [CELL_W-1:0] row_prior [MAX_COLS];
   logic [CELL_W-1:0] row_last  [MAX_COLS];
   logic [CELL_W-1:0] west_val = '0;
   int row_pos = 0;
   int col_pos = 0;

   sweep_out_type expected_cells [$];
   sweep_op_type  op_queue [$];

   int cells_queued = 0;
   int cells_sent = 0;
   int results_seen = 0;
   int mismatches = 0;
   int grid_writes = 0;
   int drains = 0;
   int holds_done = 0;
   int cycle_count = 0;

   function automatic int grid_edge();
      if (grid_reg < jss_pkg::MIN_GRID) return jss_pkg::MIN_GRID;
      if (grid_reg > MAX_COLS) return MAX_COLS;
      return int'(grid_reg);
   endfunction

   function automatic int clamp_edge(input int side);
      if (side < jss_pkg::MIN_GRID) return jss_pkg::MIN_GRID;
      if (side > MAX_COLS) return MAX_COLS;
      return side;
   endfunction

   task automatic apply_grid_size(input logic [jss_pkg::GRID_SIZE_WIDTH-1:0] side);
      grid_reg = side;
      row_pos  = 0;
      col_pos  = 0;
      west_val = '0;
   endtask

   task automatic predict_cell(input logic [CELL_W-1:0] x);
      int n;
      int r;
      int c;
      int cnt;
      logic [CELL_W-1:0] centre;
      logic [CELL_W-1:0] east;
      logic [CELL_W+1:0] total;
      sweep_out_type res [2];
      n = grid_edge();
      r = row_pos;
      c = col_pos;
      cnt = 0;
      if (r >= n || c >= n) begin
         r = 0;
         c = 0;
      end
      centre = row_last[c];
      if (r >= 1) begin
         if (r == 1 || c == 0 || c == n - 1) begin
            res[0].new_value = centre;
         end else begin
            east = row_last[c + 1];
            total = row_prior[c] + x + west_val + east;
            res[0].new_value = total[CELL_W+1:2];
         end
         cnt = 1;
      end
      // In the final row the input itself comes out again as a boundary value.
      if (r == n - 1) begin
         res[cnt].new_value = x;
         cnt++;
      end
      for (int i = 0; i < cnt; i++) begin
         res[i].last_of_run = (i == cnt - 1);
         res[i].frame_done  = (i == cnt - 1) && (r == n - 1) && (c == n - 1);
         expected_cells.push_back(res[i]);
      end
      west_val = centre;
      row_prior[c] = centre;
      row_last[c] = x;
      c++;
      if (c >= n) begin
         c = 0;
         west_val = '0;
         r++;
         if (r >= n) r = 0;
      end
      col_pos = c;
      row_pos = r;
   endtask

   function automatic int pick_idle_pct();
      case ($urandom_range(4))
         0, 1: return 0;
         2: return 15;
         3: return 40;
         default: return 70;
      endcase
   endfunction

   function automatic logic [CELL_W-1:0] pick_value();
      case ($urandom_range(9))
         0: return '0;
         1: return ONE_VAL;
         2: return MAX_VAL;
         3: return CELL_W'($urandom_range(7));
         4, 5: return CELL_W'($urandom_range(int'(ONE_VAL)));
         default: return CELL_W'($urandom());
      endcase
   endfunction

   task automatic queue_cell(input logic [CELL_W-1:0] v);
      op_queue.push_back('{OP_CELL, v});
      cells_queued++;
   endtask

   task automatic queue_drain();
      op_queue.push_back('{OP_DRAIN, '0});
   endtask

   // A grid size write only ever follows a full drain of the result stream.
   task automatic queue_grid(input int side);
      queue_drain();
      op_queue.push_back('{OP_GRID, CELL_W'(side)});
   endtask

   function automatic logic quiet_tail();
      return op_queue.size() < QUIET_OPS;
   endfunction

   // Driver: feeds pending transactions and grid size writes to the block.
   int send_idle_pct = 0;
   int gap_left = 0;
   int settle_left = 0;
   logic draining = 1'b0;

   always @(posedge clock) begin : drive_proc
      logic hold;
      logic nxt_valid;
      logic nxt_we;
      logic [CELL_W-1:0] nxt_cell;
      logic [jss_pkg::GRID_SIZE_WIDTH-1:0] nxt_grid;
      sweep_op_type op;
      if (reset) begin
         req_valid <= 1'b0;
         csr_write_enable <= 1'b0;
      end else begin
         hold = req_valid && !req_ready;
         if (req_valid && req_ready) begin
            predict_cell(req_cell_value);
            cells_sent++;
            if (cells_sent % 64 == 0) send_idle_pct = pick_idle_pct();
         end
         nxt_valid = hold;
         nxt_cell = req_cell_value;
         nxt_we = 1'b0;
         nxt_grid = csr_write_data;
         if (!hold) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (settle_left > 0) begin
               settle_left--;
            end else if (draining) begin
               if (expected_cells.size() == 0) begin
                  draining = 1'b0;
                  settle_left = SETTLE_CYCLES;
               end
            end else if (op_queue.size() != 0) begin
               if (!quiet_tail() && op_queue[0].kind == OP_CELL &&
                   $urandom_range(99) < send_idle_pct) begin
                  gap_left = $urandom_range(1, 9) - 1;
               end else begin
                  op = op_queue.pop_front();
                  case (op.kind)
                     OP_CELL: begin
                        nxt_valid = 1'b1;
                        nxt_cell = op.value;
                     end
                     OP_GRID: begin
                        nxt_we = 1'b1;
                        nxt_grid = op.value[jss_pkg::GRID_SIZE_WIDTH-1:0];
                        apply_grid_size(op.value[jss_pkg::GRID_SIZE_WIDTH-1:0]);
                        grid_writes++;
                     end
                     default: begin
                        draining = 1'b1;
                        drains++;
                     end
                  endcase
               end
            end
         end
         req_valid <= nxt_valid;
         req_cell_value <= nxt_cell;
         csr_write_enable <= nxt_we;
         csr_write_data <= nxt_grid;
      end
   end

   // Monitor: checks each result transaction and throttles the result port.
   int recv_idle_pct = 0;
   int stall_left = 0;
   int hold_left = 0;

   always @(posedge clock) begin : monitor_proc
      logic nxt_ready;
      sweep_out_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_cells.size() == 0) begin
               $display("%0t ns: unexpected result, expected none, actual value %h last %b done %b",
                        $time, rsp_new_value, rsp_last_of_run, rsp_frame_done);
               mismatches++;
            end else begin
               want = expected_cells.pop_front();
               if (rsp_new_value !== want.new_value) begin
                  $display("%0t ns: new_value mismatch, expected %h, actual %h",
                           $time, want.new_value, rsp_new_value);
                  mismatches++;
               end
               if (rsp_last_of_run !== want.last_of_run) begin
                  $display("%0t ns: last_of_run mismatch, expected %b, actual %b",
                           $time, want.last_of_run, rsp_last_of_run);
                  mismatches++;
               end
               if (rsp_frame_done !== want.frame_done) begin
                  $display("%0t ns: frame_done mismatch, expected %b, actual %b",
                           $time, want.frame_done, rsp_frame_done);
                  mismatches++;
               end
            end
            results_seen++;
            if (results_seen % 64 == 0) recv_idle_pct = pick_idle_pct();
         end
         // Long holds start only while the sender is offering, so the block backs up.
         if (hold_left > 0) begin
            hold_left--;
            nxt_ready = 1'b0;
         end else if (holds_done < 2 && results_seen >= 400 * (holds_done + 1) && req_valid) begin
            holds_done++;
            hold_left = LONG_HOLD - 1;
            nxt_ready = 1'b0;
         end else if (quiet_tail()) begin
            nxt_ready = 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            nxt_ready = 1'b0;
         end else if ($urandom_range(99) < recv_idle_pct) begin
            stall_left = $urandom_range(1, 9) - 1;
            nxt_ready = 1'b0;
         end else begin
            nxt_ready = 1'b1;
         end
         rsp_ready <= nxt_ready;
      end
   end

   always @(posedge clock) begin : watchdog_proc
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t ns: timeout with %0d results still outstanding",
                  $time, expected_cells.size());
         $display("** jacobi_stencil_sweep: FAILED **");
         $finish;
      end
   end

   initial begin : stimulus_proc
      int side;
      int n;
      int count;
      int sel;
      int target;
      foreach (row_prior[i]) begin
         row_prior[i] = '0;
         row_last[i] = '0;
      end

      // Smallest grid: extremes around one interior point, then a wrapped frame
      // with truncation, then clamped sizes: one cut off mid-frame, one whole frame.
      queue_grid(3);
      queue_cell('0);
      queue_cell(MAX_VAL);
      queue_cell(ONE_VAL);
      queue_cell(MAX_VAL);
      queue_cell('0);
      queue_cell(MAX_VAL);
      queue_cell(ONE_VAL);
      queue_cell(MAX_VAL);
      queue_cell('0);
      queue_cell(25'd5);
      queue_cell(25'd1);
      queue_cell(25'd7);
      queue_cell(25'd1);
      queue_cell(25'd9);
      queue_cell(25'd0);
      queue_cell(25'd3);
      queue_cell(25'd1);
      queue_cell(25'd2);
      queue_grid(0);
      for (int i = 0; i < 7; i++) queue_cell(pick_value());
      queue_grid(1);
      for (int i = 0; i < 9; i++) queue_cell(pick_value());

      // Widest rows: an oversized setting, then the full width; both are cut off
      // inside their first row.
      queue_grid(4095);
      for (int i = 0; i < WIDE_CELLS; i++) queue_cell(pick_value());
      queue_grid(MAX_COLS);
      for (int i = 0; i < WIDE_CELLS; i++) queue_cell(pick_value());

      // Mostly small grids with whole frames; some frames are cut short.
      target = cells_queued + RANDOM_CELLS;
      while (cells_queued < target) begin
         sel = $urandom_range(99);
         if (sel < 6) side = $urandom_range(2);
         else if (sel < 16) side = $urandom_range(13, 24);
         else side = $urandom_range(3, 12);
         queue_grid(side);
         n = clamp_edge(side);
         if ($urandom_range(3) == 0) count = $urandom_range(1, n * n - 1);
         else if (n > 12) count = n * n;
         else count = n * n * $urandom_range(1, 3);
         repeat (count) queue_cell(pick_value());
         if ($urandom_range(4) == 0) queue_drain();
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      while (!(op_queue.size() == 0 && !req_valid && !draining && gap_left == 0 &&
               settle_left == 0 && expected_cells.size() == 0))
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (expected_cells.size() != 0) begin
         $display("%0t ns: %0d expected results never arrived", $time, expected_cells.size());
         mismatches++;
      end
      $display("Swept %0d cells under %0d grid size writes and checked %0d results.",
               cells_sent, grid_writes, results_seen);
      $display("Sender drained %0d times, result port held off %0d times, %0d mismatches.",
               drains, holds_done, mismatches);
      if (mismatches == 0) begin
         $display("** jacobi_stencil_sweep: PASSED **");
      end else begin
         $display("** jacobi_stencil_sweep: FAILED **");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
hw/rtl/jss_pkg.sv
hw/rtl/jss_ram.sv
hw/rtl/jacobi_stencil_sweep.sv
hw/rtl/jss_checker.sv
sim/jacobi_stencil_sweep_tb.sv
